FILE: hdl/fsk4_pkg.sv
package fsk4_pkg;

    // widths fixed by the word layout
    localparam int unsigned LEVEL_W      = 8;
    localparam int unsigned GAIN_W       = 7;
    localparam int unsigned PHASE_W      = 32;
    localparam int unsigned LEN_W        = 16;
    localparam int unsigned REPEAT_W     = 4;
    localparam int unsigned SYM_IDX_W    = 4;
    localparam int unsigned CFG_ADDR_W   = 3;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned S_TDATA_W    = 8;
    localparam int unsigned S_TUSER_W    = 2;
    localparam int unsigned M_TDATA_W    = 16;

    localparam int unsigned COUNT_BITS_DEFAULT = 16;

    localparam logic [LEVEL_W-1:0]   MID_LEVEL = 8'd128;
    localparam logic [LEVEL_W-1:0]   LEVEL_MIN = 8'd1;
    localparam logic [LEVEL_W-1:0]   LEVEL_MAX = 8'd254;
    localparam logic [GAIN_W-1:0]    BASE_GAIN = 7'd80;
    localparam logic [SYM_IDX_W-1:0] FRAME_LEN = 4'd12;
    localparam logic [3:0]           MAX_DIGIT = 4'd9;
    localparam logic [1:0]           SYM_INVERT = 2'b11;

    // floor(x / 5) == (x * 205) >> 10 for x below 1024
    localparam logic [7:0] DIV5_RECIP = 8'd205;
    localparam int unsigned DIV5_SHIFT = 10;

    // register defaults
    localparam logic [LEN_W-1:0]    TONE_LEN_RST     = 16'd3840;
    localparam logic [LEN_W-1:0]    GAP_LEN_RST      = 16'd1920;
    localparam logic [REPEAT_W-1:0] REPEAT_COUNT_RST = 4'd3;
    localparam logic [PHASE_W-1:0]  PHASE_STEP0_RST  = 32'd201326592;
    localparam logic [PHASE_W-1:0]  PHASE_STEP1_RST  = 32'd335544320;
    localparam logic [PHASE_W-1:0]  PHASE_STEP2_RST  = 32'd469762048;
    localparam logic [PHASE_W-1:0]  PHASE_STEP3_RST  = 32'd603979776;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TONE_LEN     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP_LEN      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_COUNT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP0  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP1  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP2  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP3  = 3'd6;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_DIGIT = 2'd1,
        OP_TEST  = 2'd2,
        OP_STOP  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_TONE = 2'd1,
        MODE_GAP  = 2'd2,
        MODE_TEST = 2'd3
    } mode_t;

    typedef struct packed {
        logic                test_mode;
        logic                active;
        logic [LEVEL_W-1:0]  level;
    } result_t;

    // one quarter-wave-symmetric sine cycle around the mid level
    function automatic logic [LEVEL_W-1:0] fsk4_sine(input logic [5:0] idx);
        logic [LEVEL_W-1:0] v;
        unique case (idx)
            6'd0:  v = 8'd128;  6'd1:  v = 8'd136;  6'd2:  v = 8'd144;  6'd3:  v = 8'd151;
            6'd4:  v = 8'd159;  6'd5:  v = 8'd166;  6'd6:  v = 8'd172;  6'd7:  v = 8'd179;
            6'd8:  v = 8'd185;  6'd9:  v = 8'd190;  6'd10: v = 8'd195;  6'd11: v = 8'd199;
            6'd12: v = 8'd202;  6'd13: v = 8'd205;  6'd14: v = 8'd206;  6'd15: v = 8'd208;
            6'd16: v = 8'd208;  6'd17: v = 8'd208;  6'd18: v = 8'd206;  6'd19: v = 8'd205;
            6'd20: v = 8'd202;  6'd21: v = 8'd199;  6'd22: v = 8'd195;  6'd23: v = 8'd190;
            6'd24: v = 8'd185;  6'd25: v = 8'd179;  6'd26: v = 8'd172;  6'd27: v = 8'd166;
            6'd28: v = 8'd159;  6'd29: v = 8'd151;  6'd30: v = 8'd144;  6'd31: v = 8'd136;
            6'd32: v = 8'd128;  6'd33: v = 8'd120;  6'd34: v = 8'd112;  6'd35: v = 8'd105;
            6'd36: v = 8'd97;   6'd37: v = 8'd90;   6'd38: v = 8'd84;   6'd39: v = 8'd77;
            6'd40: v = 8'd71;   6'd41: v = 8'd66;   6'd42: v = 8'd61;   6'd43: v = 8'd57;
            6'd44: v = 8'd54;   6'd45: v = 8'd51;   6'd46: v = 8'd50;   6'd47: v = 8'd48;
            6'd48: v = 8'd48;   6'd49: v = 8'd48;   6'd50: v = 8'd50;   6'd51: v = 8'd51;
            6'd52: v = 8'd54;   6'd53: v = 8'd57;   6'd54: v = 8'd61;   6'd55: v = 8'd66;
            6'd56: v = 8'd71;   6'd57: v = 8'd77;   6'd58: v = 8'd84;   6'd59: v = 8'd90;
            6'd60: v = 8'd97;   6'd61: v = 8'd105;  6'd62: v = 8'd112;  default: v = 8'd120;
        endcase
        return v;
    endfunction

    function automatic logic [GAIN_W-1:0] fsk4_gain(input logic [1:0] sym);
        logic [GAIN_W-1:0] g;
        unique case (sym)
            2'd0:    g = 7'd50;
            2'd1:    g = 7'd72;
            default: g = 7'd126;
        endcase
        return g;
    endfunction

    // codebook pair for a digit, first symbol in the upper two bits
    function automatic logic [3:0] fsk4_digit_code(input logic [3:0] d);
        logic [3:0] c;
        unique case (d)
            4'd0:    c = {2'd0, 2'd1};
            4'd1:    c = {2'd0, 2'd2};
            4'd2:    c = {2'd0, 2'd3};
            4'd3:    c = {2'd1, 2'd0};
            4'd4:    c = {2'd1, 2'd2};
            4'd5:    c = {2'd1, 2'd3};
            4'd6:    c = {2'd2, 2'd0};
            4'd7:    c = {2'd2, 2'd1};
            4'd8:    c = {2'd2, 2'd3};
            4'd9:    c = {2'd3, 2'd0};
            default: c = 4'd0;
        endcase
        return c;
    endfunction

    // frame layout: preamble, start, code pair, inverted pair, end
    function automatic logic [1:0] fsk4_frame_sym(input logic [SYM_IDX_W-1:0] idx,
                                                  input logic [1:0] code_a,
                                                  input logic [1:0] code_b);
        logic [1:0] s;
        unique case (idx)
            4'd1:    s = 2'd1;
            4'd2:    s = 2'd2;
            4'd3:    s = 2'd3;
            4'd4:    s = 2'd1;
            4'd5:    s = 2'd2;
            4'd6:    s = code_a;
            4'd7:    s = code_b;
            4'd8:    s = code_a ^ SYM_INVERT;
            4'd9:    s = code_b ^ SYM_INVERT;
            4'd10:   s = 2'd2;
            4'd11:   s = 2'd3;
            default: s = 2'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/fsk4_tone_frame_generator_core.sv
// four-tone fsk frame generator: one command word in, one level word out
// output: the result word goes into the output register when it is free or being taken, else into the skid word
// throughput: one command word per cycle while the skid word is empty; a two-word output register/skid pair keeps
//   s_axis_tready high while a single result waits downstream
// reset: aresetn is synchronous, active low; clears the sequencer and handshake state
//   and loads the default tone/gap lengths, repeat count and phase steps
module fsk4_tone_frame_generator_core #(
    parameter int unsigned COUNT_BITS = fsk4_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fsk4_pkg::S_TDATA_W-1:0]      s_axis_tdata,   // digit[3:0], tone_bits[5:4], zero pad
    input  logic [fsk4_pkg::S_TUSER_W-1:0]      s_axis_tuser,   // opcode[1:0]

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fsk4_pkg::M_TDATA_W-1:0]      m_axis_tdata,   // level[7:0], active[8], test_mode[9], zero pad

    input  logic                                cfg_wr_en,
    input  logic [fsk4_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [fsk4_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import fsk4_pkg::*;

    // configuration registers
    logic [LEN_W-1:0]    tone_len_reg;
    logic [LEN_W-1:0]    gap_len_reg;
    logic [REPEAT_W-1:0] repeat_count_reg;
    logic [PHASE_W-1:0]  phase_step0_reg;
    logic [PHASE_W-1:0]  phase_step1_reg;
    logic [PHASE_W-1:0]  phase_step2_reg;
    logic [PHASE_W-1:0]  phase_step3_reg;

    // sequencer state
    mode_t                  mode_reg,         mode_next;
    logic                   running_reg,      running_next;
    logic [REPEAT_W-1:0]    repeat_index_reg, repeat_index_next;
    logic [SYM_IDX_W-1:0]   symbol_index_reg, symbol_index_next;
    logic [COUNT_BITS-1:0]  samples_left_reg, samples_left_next;
    logic [PHASE_W-1:0]     phase_reg,        phase_next;
    logic [PHASE_W-1:0]     step_now_reg,     step_now_next;
    logic [GAIN_W-1:0]      gain_now_reg,     gain_now_next;
    logic [LEVEL_W-1:0]     last_level_reg,   last_level_next;

    // codebook pair of the current frame; the fixed symbols need no storage
    logic [1:0]             code_a_reg,       code_a_next;
    logic [1:0]             code_b_reg,       code_b_next;

    // output register and skid word
    logic                   out_valid_reg,    out_valid_next;
    result_t                out_word_reg,     out_word_next;
    logic                   skid_valid_reg,   skid_valid_next;
    result_t                skid_word_reg,    skid_word_next;

    // command word fields
    opcode_t                in_op;
    logic [3:0]             in_digit;
    logic [1:0]             in_tone_bits;
    logic                   in_accept;
    logic                   out_take;
    result_t                result;

    assign in_op        = opcode_t'(s_axis_tuser[1:0]);
    assign in_digit     = s_axis_tdata[3:0];
    assign in_tone_bits = s_axis_tdata[5:4];

    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_take      = out_valid_reg && m_axis_tready;

    // lengths are masked to the counter width when loaded
    logic [CFG_DATA_W-1:0]  tone_len_ext;
    logic [CFG_DATA_W-1:0]  gap_len_ext;
    logic [COUNT_BITS-1:0]  tone_load;
    logic [COUNT_BITS-1:0]  gap_load;

    assign tone_len_ext = CFG_DATA_W'(tone_len_reg);
    assign gap_len_ext  = CFG_DATA_W'(gap_len_reg);
    assign tone_load    = tone_len_ext[COUNT_BITS-1:0];
    assign gap_load     = gap_len_ext[COUNT_BITS-1:0];

    // a tick that opens the next tone of the frame
    logic        tick_load;
    logic [1:0]  frame_sym;
    logic [1:0]  step_sel;
    logic [PHASE_W-1:0] step_sel_val;

    assign frame_sym = fsk4_frame_sym(symbol_index_reg, code_a_reg, code_b_reg);
    assign tick_load = running_reg && (mode_reg != MODE_TEST) && (mode_reg != MODE_TONE)
                       && (samples_left_reg == '0) && (repeat_index_reg < repeat_count_reg);

    // one phase step lookup, shared between frame tones and the test tone
    assign step_sel = (in_op == OP_TEST) ? in_tone_bits : frame_sym;

    always_comb begin
        unique case (step_sel)
            2'd0:    step_sel_val = phase_step0_reg;
            2'd1:    step_sel_val = phase_step1_reg;
            2'd2:    step_sel_val = phase_step2_reg;
            default: step_sel_val = phase_step3_reg;
        endcase
    end

    // sample scaler: 128 + trunc((rom - 128) * gain / 80), clamped to 1..254
    logic [PHASE_W-1:0]     scale_phase;
    logic [GAIN_W-1:0]      scale_gain;
    logic [LEVEL_W-1:0]     rom_val;
    logic                   dev_neg;
    logic [LEVEL_W-1:0]     dev_diff;
    logic [6:0]             dev_mag;
    logic [13:0]            prod;
    logic [9:0]             prod_div16;
    logic [17:0]            recip_prod;
    logic [6:0]             quot;
    logic [8:0]             level_sum;
    logic [LEVEL_W-1:0]     scaled_level;

    assign scale_phase = tick_load ? '0 : phase_reg;
    assign scale_gain  = tick_load ? fsk4_gain(frame_sym) : gain_now_reg;
    assign rom_val     = fsk4_sine(scale_phase[PHASE_W-1 -: 6]);
    assign dev_neg     = rom_val < MID_LEVEL;
    assign dev_diff    = dev_neg ? (MID_LEVEL - rom_val) : (rom_val - MID_LEVEL);
    assign dev_mag     = dev_diff[6:0];
    assign prod        = 14'(dev_mag) * 14'(scale_gain);
    // divide magnitude by 80 as a shift by 4 (divide by 16) then an exact reciprocal divide by 5
    assign prod_div16  = prod[13:4];
    assign recip_prod  = 18'(prod_div16) * 18'(DIV5_RECIP);
    assign quot        = recip_prod[DIV5_SHIFT +: 7];
    assign level_sum   = dev_neg ? (9'(MID_LEVEL) - 9'(quot)) : (9'(MID_LEVEL) + 9'(quot));

    always_comb begin
        if (level_sum < 9'(LEVEL_MIN)) begin
            scaled_level = LEVEL_MIN;
        end else if (level_sum > 9'(LEVEL_MAX)) begin
            scaled_level = LEVEL_MAX;
        end else begin
            scaled_level = level_sum[LEVEL_W-1:0];
        end
    end

    // command decode and sequencer next state
    always_comb begin
        logic [3:0]            code_pair;
        mode_t                 mode_v;
        logic [COUNT_BITS-1:0] left_v;

        code_pair = fsk4_digit_code(in_digit);
        mode_v    = mode_reg;
        left_v    = samples_left_reg;

        mode_next         = mode_reg;
        running_next      = running_reg;
        repeat_index_next = repeat_index_reg;
        symbol_index_next = symbol_index_reg;
        samples_left_next = samples_left_reg;
        phase_next        = phase_reg;
        step_now_next     = step_now_reg;
        gain_now_next     = gain_now_reg;
        last_level_next   = last_level_reg;
        code_a_next       = code_a_reg;
        code_b_next       = code_b_reg;

        if (in_accept) begin
            unique case (in_op)
                OP_TICK: begin
                    if (!running_reg) begin
                        last_level_next = MID_LEVEL;
                    end else if (mode_reg == MODE_TEST) begin
                        last_level_next = scaled_level;
                        phase_next      = phase_reg + step_now_reg;
                    end else begin
                        if (left_v == '0) begin
                            if (mode_reg == MODE_TONE) begin
                                mode_v = MODE_GAP;
                                left_v = gap_load;
                            end else if (!tick_load) begin
                                // all repeats sent: frame ends
                                running_next  = 1'b0;
                                mode_v        = MODE_IDLE;
                                left_v        = '0;
                                step_now_next = '0;
                                gain_now_next = BASE_GAIN;
                            end else begin
                                step_now_next = step_sel_val;
                                gain_now_next = fsk4_gain(frame_sym);
                                left_v        = tone_load;
                                mode_v        = MODE_TONE;
                                if (symbol_index_reg >= FRAME_LEN - 4'd1) begin
                                    symbol_index_next = '0;
                                    repeat_index_next = repeat_index_reg + 4'd1;
                                end else begin
                                    symbol_index_next = symbol_index_reg + 4'd1;
                                end
                            end
                        end
                        if (mode_v == MODE_TONE) begin
                            last_level_next = scaled_level;
                            phase_next      = scale_phase + step_now_next;
                        end else begin
                            last_level_next = MID_LEVEL;
                        end
                        if (left_v != '0) begin
                            left_v = left_v - 1'b1;
                        end
                        mode_next         = mode_v;
                        samples_left_next = left_v;
                    end
                end
                OP_DIGIT: begin
                    // out-of-range digits are ignored
                    if (in_digit <= MAX_DIGIT) begin
                        code_a_next       = code_pair[3:2];
                        code_b_next       = code_pair[1:0];
                        repeat_index_next = '0;
                        symbol_index_next = '0;
                        samples_left_next = '0;
                        phase_next        = '0;
                        step_now_next     = '0;
                        mode_next         = MODE_GAP;
                        running_next      = 1'b1;
                        last_level_next   = MID_LEVEL;
                    end
                end
                OP_TEST: begin
                    // level keeps its value until the next tick
                    repeat_index_next = '0;
                    symbol_index_next = '0;
                    samples_left_next = '0;
                    phase_next        = '0;
                    step_now_next     = step_sel_val;
                    gain_now_next     = fsk4_gain(in_tone_bits);
                    mode_next         = MODE_TEST;
                    running_next      = 1'b1;
                end
                default: begin
                    // stop keeps the phase
                    running_next      = 1'b0;
                    mode_next         = MODE_IDLE;
                    samples_left_next = '0;
                    step_now_next     = '0;
                    gain_now_next     = BASE_GAIN;
                    last_level_next   = MID_LEVEL;
                end
            endcase
        end
    end

    // result word built from the updated state
    always_comb begin
        result.level     = last_level_next;
        result.active    = running_next;
        result.test_mode = running_next && (mode_next == MODE_TEST);
    end

    // output register with one skid word behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next  = skid_word_reg;

        if (!out_valid_reg || out_take) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_accept;
                out_word_next  = result;
            end
        end else if (in_accept) begin
            skid_valid_next = 1'b1;
            skid_word_next  = result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_word_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_len_reg     <= TONE_LEN_RST;
            gap_len_reg      <= GAP_LEN_RST;
            repeat_count_reg <= REPEAT_COUNT_RST;
            phase_step0_reg  <= PHASE_STEP0_RST;
            phase_step1_reg  <= PHASE_STEP1_RST;
            phase_step2_reg  <= PHASE_STEP2_RST;
            phase_step3_reg  <= PHASE_STEP3_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_TONE_LEN:     tone_len_reg     <= cfg_wdata[LEN_W-1:0];
                REG_GAP_LEN:      gap_len_reg      <= cfg_wdata[LEN_W-1:0];
                REG_REPEAT_COUNT: repeat_count_reg <= cfg_wdata[REPEAT_W-1:0];
                REG_PHASE_STEP0:  phase_step0_reg  <= cfg_wdata[PHASE_W-1:0];
                REG_PHASE_STEP1:  phase_step1_reg  <= cfg_wdata[PHASE_W-1:0];
                REG_PHASE_STEP2:  phase_step2_reg  <= cfg_wdata[PHASE_W-1:0];
                REG_PHASE_STEP3:  phase_step3_reg  <= cfg_wdata[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and handshake control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_IDLE;
            running_reg      <= 1'b0;
            repeat_index_reg <= '0;
            symbol_index_reg <= '0;
            samples_left_reg <= '0;
            phase_reg        <= '0;
            step_now_reg     <= '0;
            gain_now_reg     <= BASE_GAIN;
            last_level_reg   <= MID_LEVEL;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            mode_reg         <= mode_next;
            running_reg      <= running_next;
            repeat_index_reg <= repeat_index_next;
            symbol_index_reg <= symbol_index_next;
            samples_left_reg <= samples_left_next;
            phase_reg        <= phase_next;
            step_now_reg     <= step_now_next;
            gain_now_reg     <= gain_now_next;
            last_level_reg   <= last_level_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    // payload only
    always_ff @(posedge aclk) begin
        code_a_reg    <= code_a_next;
        code_b_reg    <= code_b_next;
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    // checks on the sequencer and the output buffering
    a_idle_when_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (mode_reg == MODE_IDLE) && (samples_left_reg == '0))
        else $error("sequencer stopped but mode or counter not cleared");

    a_mid_level_when_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (last_level_reg == MID_LEVEL))
        else $error("level not at mid while stopped");

    a_symbol_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        symbol_index_reg < FRAME_LEN)
        else $error("symbol index past end of frame");

    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg && $past(out_valid_reg) && !$past(m_axis_tready))
        else $error("skid word held without a stalled output word");

endmodule
